FILE: hw/rtl/lru_recency_tracker_defines.svh
// Assertion macros for the LRU recency tracker.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef LRU_RECENCY_TRACKER_DEFINES_SVH
`define LRU_RECENCY_TRACKER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define LRT_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lru tracker invariant violated");

// Check a consequence in the same cycle as its antecedent.
`define LRT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru tracker same-cycle check failed");

// Check a consequence in the cycle after its antecedent.
`define LRT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru tracker next-cycle check failed");

`endif

FILE: hw/rtl/lrt_pkg.sv
// Shared types and codes for the LRU recency tracker.
// No dependencies; imported by lru_recency_tracker.
`timescale 1ns / 1ps

package lrt_pkg;

    localparam int KEY_W   = 16;
    localparam int COUNT_W = 5;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_PUT    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [2:0] ST_TOUCHED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_ABSENT   = 3'd4;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
    } lrt_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [KEY_W-1:0]   lru_key;
        logic               lru_valid;
        logic [COUNT_W-1:0] count;
    } lrt_out_t;

endpackage

FILE: hw/rtl/lru_recency_tracker.sv
// LRU recency tracker top level: key/rank memory, valid bits and sweep sequencer.
// Depends on lrt_pkg and lru_recency_tracker_defines.svh.
`timescale 1ns / 1ps
`include "lru_recency_tracker_defines.svh"

// Usage:
//   Command channel: a transaction (cmd.op, cmd.key) is taken at a clock edge with
//   start high and busy low. busy stays high until the result is produced.
//   Result channel: done pulses for one cycle with result valid in that cycle;
//   the receiver cannot stall, so it must capture the result then.
//   Configuration: cfg_we writes cfg_data into the capacity register; write it
//   only while busy is low and no result is pending.
// Operation:
//   Each transaction sweeps the key/rank memory (one read port, one write port)
//   twice, one entry per cycle: once to find the key and a free slot, once to
//   adjust ranks and locate the least recent key. A new command may be accepted
//   in the cycle done is high.
// Reset:
//   rst_n clears all valid bits, the count and the sequencer; capacity
//   returns to 16. Memory contents are not cleared.
module lru_recency_tracker #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  lrt_pkg::lrt_in_t            cmd,
    output logic                        done,
    output lrt_pkg::lrt_out_t           result,
    input  logic                        cfg_we,
    input  logic [lrt_pkg::CAP_W-1:0]   cfg_data
);
    import lrt_pkg::*;

    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int RW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int MW = KW + RW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DEC  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [MW-1:0] key_rank_mem [MAX_ENTRIES];
    logic [MW-1:0] rd_q_reg;
    logic          mem_we;
    logic [RW-1:0] mem_wa;
    logic [MW-1:0] mem_wd;
    logic [RW-1:0] rd_addr;

    logic [1:0]             state_reg, state_next;
    logic                   op_reg, op_next;
    logic [KW-1:0]          key_reg, key_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [RW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic                   hit_reg, hit_next;
    logic [RW-1:0]          hit_idx_reg, hit_idx_next;
    logic [RW-1:0]          hit_rank_reg, hit_rank_next;
    logic                   free_reg, free_next;
    logic [RW-1:0]          free_idx_reg, free_idx_next;
    logic [2:0]             status_reg, status_next;
    logic                   shift_en_reg, shift_en_next;
    logic                   tgt_en_reg, tgt_en_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [CAP_W-1:0]       cap_reg, cap_next;
    logic                   lru_found_reg, lru_found_next;
    logic [KW-1:0]          lru_key_reg, lru_key_next;
    logic                   done_reg, done_next;
    lrt_out_t               result_reg, result_next;

    logic [KW-1:0] q_key;
    logic [RW-1:0] q_rank;
    logic [RW-1:0] new_rank;
    logic          q_valid;
    logic          tracker_full;

    assign q_key   = rd_q_reg[MW-1:RW];
    assign q_rank  = rd_q_reg[RW-1:0];
    assign q_valid = valid_reg[cmp_idx_reg];
    assign rd_addr = cnt_reg[RW-1:0];

    assign tracker_full = int'(count_reg) >=
                          ((int'(cap_reg) > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_reg));

    always_comb
    begin
        if (tgt_en_reg && (cmp_idx_reg == hit_idx_reg))
        begin
            new_rank = RW'(count_reg - CW'(1));
        end
        else if (shift_en_reg && (q_rank > hit_rank_reg))
        begin
            new_rank = q_rank - RW'(1);
        end
        else
        begin
            new_rank = q_rank;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        cnt_next       = cnt_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_rank_next  = hit_rank_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        status_next    = status_reg;
        shift_en_next  = shift_en_reg;
        tgt_en_next    = tgt_en_reg;
        count_next     = count_reg;
        valid_next     = valid_reg;
        cap_next       = cfg_we ? cfg_data : cap_reg;
        lru_found_next = lru_found_reg;
        lru_key_next   = lru_key_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        mem_we         = 1'b0;
        mem_wa         = cmp_idx_reg;
        mem_wd         = {q_key, new_rank};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = cmd.op;
                    key_next   = cmd.key[KW-1:0];
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (int'(cnt_reg) < MAX_ENTRIES)
                begin
                    cnt_next     = cnt_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_addr;
                end
                else
                begin
                    state_next = S_DEC;
                end
                if (cmp_vld_reg)
                begin
                    if (q_valid && (q_key == key_reg))
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = cmp_idx_reg;
                        hit_rank_next = q_rank;
                    end
                    if (!q_valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                end
            end
            S_DEC:
            begin
                shift_en_next  = 1'b0;
                tgt_en_next    = 1'b0;
                cnt_next       = '0;
                lru_found_next = 1'b0;
                lru_key_next   = '0;
                state_next     = S_UPD;
                if (op_reg == OP_PUT)
                begin
                    if (hit_reg)
                    begin
                        status_next   = ST_TOUCHED;
                        shift_en_next = 1'b1;
                        tgt_en_next   = 1'b1;
                    end
                    else if (tracker_full || !free_reg)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next              = ST_INSERTED;
                        mem_we                   = 1'b1;
                        mem_wa                   = free_idx_reg;
                        mem_wd                   = {key_reg, RW'(count_reg)};
                        valid_next[free_idx_reg] = 1'b1;
                        count_next               = count_reg + CW'(1);
                    end
                end
                else
                begin
                    if (hit_reg)
                    begin
                        status_next             = ST_REMOVED;
                        shift_en_next           = 1'b1;
                        valid_next[hit_idx_reg] = 1'b0;
                        count_next              = count_reg - CW'(1);
                    end
                    else
                    begin
                        status_next = ST_ABSENT;
                    end
                end
            end
            S_UPD:
            begin
                if (int'(cnt_reg) < MAX_ENTRIES)
                begin
                    cnt_next     = cnt_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_addr;
                end
                if (cmp_vld_reg && q_valid)
                begin
                    mem_we = 1'b1;
                    if ((new_rank == '0) && !lru_found_reg)
                    begin
                        lru_found_next = 1'b1;
                        lru_key_next   = q_key;
                    end
                end
                if (int'(cnt_reg) >= MAX_ENTRIES)
                begin
                    state_next            = S_IDLE;
                    done_next             = 1'b1;
                    result_next.status    = status_reg;
                    result_next.lru_key   = KEY_W'(lru_key_next);
                    result_next.lru_valid = lru_found_next;
                    result_next.count     = COUNT_W'(count_reg);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_rank_mem[mem_wa] <= mem_wd;
        end
        rd_q_reg <= key_rank_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmp_vld_reg   <= 1'b0;
            count_reg     <= '0;
            valid_reg     <= '0;
            cap_reg       <= CAP_RESET;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_vld_reg   <= cmp_vld_next;
            count_reg     <= count_next;
            valid_reg     <= valid_next;
            cap_reg       <= cap_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        cnt_reg       <= cnt_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        hit_rank_reg  <= hit_rank_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        status_reg    <= status_next;
        shift_en_reg  <= shift_en_next;
        tgt_en_reg    <= tgt_en_next;
        lru_found_reg <= lru_found_next;
        lru_key_reg   <= lru_key_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `LRT_ASSERT(a_count_matches_valid, $countones(valid_reg) == int'(count_reg))
    `LRT_ASSERT(a_count_bounded, int'(count_reg) <= MAX_ENTRIES)
    `LRT_ASSERT_NXT(a_accept_starts_scan, start && !busy, state_reg == S_SCAN)
    `LRT_ASSERT_IMP(a_done_when_idle, done, state_reg == S_IDLE)
    `LRT_ASSERT_IMP(a_lru_iff_nonempty, done, result.lru_valid == (count_reg != '0))

endmodule
